### src/sha256_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and SHA-256 helper functions for the stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;
  // Eight words, index 0 is a / H0.
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_t;

  // Message window control: load shifts in a byte, step advances one word.
  typedef struct packed {
    logic       load;
    logic       step;
    logic [7:0] byte_in;
  } sched_ctl_t;

  // Round unit control: init copies the chaining value, step runs one round.
  typedef struct packed {
    logic init;
    logic step;
  } round_ctl_t;

  localparam logic [5:0] LastRound = 6'd63;
  localparam logic [5:0] LastByte  = 6'd63;
  localparam logic [2:0] LastWord  = 3'd7;
  // Upper fill bits equal to this mean the fill is at or past byte 56.
  localparam logic [2:0] LenZone   = 3'd7;
  localparam logic [7:0] PadMark   = 8'h80;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

### src/sha256_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_sched
// 512-bit message window: bytes shift in during fill, words shift out during
// rounds with the schedule word appended at the tail.
// ----------------------------------------------------------------------------
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctl_t ctl,
  output sha256_pkg::word_t      w
);

  // Oldest word sits in the top 32 bits.
  logic [511:0] win;
  sha256_pkg::word_t w_next;

  assign w = win[511:480];

  // W[t+16] from W[t], W[t+1], W[t+9], W[t+14].
  assign w_next = sha256_pkg::small_sigma1(win[63:32]) + win[223:192]
                + sha256_pkg::small_sigma0(win[479:448]) + win[511:480];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      win <= {win[503:0], ctl.byte_in};
    end else if (ctl.step) begin
      win <= {win[479:0], w_next};
    end
  end

endmodule

### src/sha256_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_round
// Working variables a..h and the single compression round shared by all
// 64 rounds.
// ----------------------------------------------------------------------------
module sha256_round (
  input  logic                   clk,
  input  sha256_pkg::round_ctl_t ctl,
  input  sha256_pkg::hash_t      chain,
  input  sha256_pkg::word_t      k,
  input  sha256_pkg::word_t      w,
  output sha256_pkg::hash_t      work
);

  sha256_pkg::word_t t1, t2, ch, maj;

  assign ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1  = work[7] + sha256_pkg::big_sigma1(work[4]) + ch + k + w;
  assign t2  = sha256_pkg::big_sigma0(work[0]) + maj;

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      work <= chain;
    end else if (ctl.step) begin
      work <= {work[6], work[5], work[4], work[3] + t1,
               work[2], work[1], work[0], t1 + t2};
    end
  end

endmodule

### src/sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// Bytes are taken one per cycle while idle; each full 64-byte block then stalls
//   input for 64 rounds on the shared round unit and one chaining add.
// End of message: 9 to 72 padding bytes, each padded block through the rounds,
//   then eight digest transfers, one per cycle when the sink does not stall.
// Reset (rst, synchronous): chaining value to the initial hash, counts cleared.
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Byte-serial SHA-256 engine: a sequencer feeds bytes and padding into the
// message window and drives one round per cycle through the round unit.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  sha256_pkg::item_t   item,
  output logic                digest_valid,
  input  logic                digest_stall,
  output sha256_pkg::digest_t digest
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROUND = 5'b00010,
    ST_FINAL = 5'b00100,
    ST_PAD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t            state;
  logic [5:0]        round_idx;
  logic [5:0]        fill;        // byte position inside the current block
  logic [60:0]       count;       // message bytes, wraps mod 2^61
  logic              pad_active;  // end of message seen, padding pending
  logic              mark_sent;   // 0x80 already placed
  logic              final_blk;   // current block carries the bit length
  logic              len_done;    // last padded block is in the rounds
  logic [2:0]        out_idx;
  sha256_pkg::hash_t chain;
  sha256_pkg::hash_t work;
  sha256_pkg::word_t w;

  sha256_pkg::sched_ctl_t sched_ctl;
  sha256_pkg::round_ctl_t round_ctl;

  logic        take_byte;
  logic        final_eff;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;

  // Only idle takes new input; every other state is busy on the current block.
  assign item_stall = (state != ST_IDLE);
  assign take_byte  = (state == ST_IDLE) && item_valid && item.byte_present;

  // Padding byte stream: the marker, then zeros, then the 64-bit bit length
  // big-endian in the last eight bytes of the final block. If the marker lands
  // past byte 55 the block is closed with zeros and one more block follows.
  assign bit_len   = {count, 3'b000};
  assign len_byte  = bit_len[{~fill[2:0], 3'b000} +: 8];
  assign final_eff = mark_sent ? final_blk : (fill[5:3] != sha256_pkg::LenZone);
  always_comb begin
    if (!mark_sent) begin
      pad_byte = sha256_pkg::PadMark;
    end else if (final_eff && (fill[5:3] == sha256_pkg::LenZone)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign sched_ctl.load    = take_byte || (state == ST_PAD);
  assign sched_ctl.step    = (state == ST_ROUND);
  assign sched_ctl.byte_in = (state == ST_PAD) ? pad_byte : item.data_byte;

  // The 64th byte of a block goes into the window in the same cycle that the
  // working variables pick up the chaining value.
  assign round_ctl.init = sched_ctl.load && (fill == sha256_pkg::LastByte);
  assign round_ctl.step = (state == ST_ROUND);

  sha256_sched u_sched (
    .clk (clk),
    .ctl (sched_ctl),
    .w   (w)
  );

  sha256_round u_round (
    .clk   (clk),
    .ctl   (round_ctl),
    .chain (chain),
    .k     (sha256_pkg::round_k(round_idx)),
    .w     (w),
    .work  (work)
  );

  // Digest words leave from the bottom of the chaining register; each
  // transfer shifts it down and refills the top with the initial hash, so the
  // register holds the initial value again after the eighth transfer.
  assign digest_valid       = (state == ST_OUT);
  assign digest.digest_word = chain[0];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == sha256_pkg::LastWord);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      round_idx  <= '0;
      fill       <= '0;
      count      <= '0;
      pad_active <= 1'b0;
      mark_sent  <= 1'b0;
      final_blk  <= 1'b0;
      len_done   <= 1'b0;
      out_idx    <= '0;
      chain      <= sha256_pkg::InitHash;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            if (item.byte_present) begin
              fill  <= fill + 6'd1;
              count <= count + 61'd1;
            end
            if (item.end_of_message) begin
              pad_active <= 1'b1;
              mark_sent  <= 1'b0;
              final_blk  <= 1'b0;
              len_done   <= 1'b0;
            end
            if (item.byte_present && (fill == sha256_pkg::LastByte)) begin
              state     <= ST_ROUND;
              round_idx <= '0;
            end else if (item.end_of_message) begin
              state <= ST_PAD;
            end
          end
        end
        ST_ROUND: begin
          round_idx <= round_idx + 6'd1;
          if (round_idx == sha256_pkg::LastRound) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (len_done) begin
            state   <= ST_OUT;
            out_idx <= '0;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PAD: begin
          fill      <= fill + 6'd1;
          mark_sent <= 1'b1;
          if (fill == sha256_pkg::LastByte) begin
            len_done  <= final_eff;
            // block closed; a following padded block always carries the length
            final_blk <= 1'b1;
            state     <= ST_ROUND;
            round_idx <= '0;
          end else if (!mark_sent) begin
            final_blk <= (fill[5:3] != sha256_pkg::LenZone);
          end
        end
        ST_OUT: begin
          if (!digest_stall) begin
            chain   <= {sha256_pkg::InitHash[out_idx], chain[7:1]};
            out_idx <= out_idx + 3'd1;
            if (out_idx == sha256_pkg::LastWord) begin
              state      <= ST_IDLE;
              count      <= '0;
              fill       <= '0;
              pad_active <= 1'b0;
              len_done   <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // No input transfer while a digest is still going out.
  a_no_take_during_out: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |-> !digest_valid)
    else $error("input transfer while digest pending");

  // The last digest transfer returns the block to accepting input.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_stall && digest.last_word) |=> !item_stall)
    else $error("not idle after last digest word");

  // Digest words come out back to back in index order.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_stall && !digest.last_word) |=>
      (digest_valid && (digest.word_index == $past(digest.word_index) + 3'd1)))
    else $error("digest word index out of order");
`endif

endmodule

### verif/sha256_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_checker
// Watches both channels of the stream hasher, keeps its own SHA-256 state,
// queues eight digest words per finished message and compares each digest
// transfer with the oldest queued word.
// ----------------------------------------------------------------------------
module sha256_hash_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_stall,
  input  sha256_pkg::item_t   item,
  input  logic                digest_valid,
  input  logic                digest_stall,
  input  sha256_pkg::digest_t digest,
  output int                  mismatches,
  output int                  words_due,
  output int                  words_checked
);

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0]         chain [8];
  logic [7:0]          blk [64];
  logic [60:0]         nbytes;
  sha256_pkg::digest_t digest_words_pending [$];
  int                  bad;
  int                  checked;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One SHA-256 compression of blk into chain.
  task automatic fold_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    int i;
    for (i = 0; i < 16; i++)
      w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
    for (i = 16; i < 64; i++)
      w[i] = (rotr(w[i - 2], 17) ^ rotr(w[i - 2], 19) ^ (w[i - 2] >> 10)) + w[i - 7]
           + (rotr(w[i - 15], 7) ^ rotr(w[i - 15], 18) ^ (w[i - 15] >> 3)) + w[i - 16];
    for (i = 0; i < 8; i++)
      v[i] = chain[i];
    for (i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++)
      chain[i] = chain[i] + v[i];
  endtask

  // Absorb one accepted item; on end of message pad, fold and queue the digest.
  task automatic absorb_item(input sha256_pkg::item_t it);
    logic [63:0] bitlen;
    int slot;
    int i;
    if (it.byte_present) begin
      slot = int'(nbytes[5:0]);
      blk[slot] = it.data_byte;
      nbytes = nbytes + 61'd1;
      if (slot == int'(sha256_pkg::LastByte))
        fold_block();
    end
    if (it.end_of_message) begin
      bitlen = {nbytes, 3'b000};
      slot = int'(nbytes[5:0]);
      blk[slot] = sha256_pkg::PadMark;
      slot++;
      // no room left for the length: spill into an extra block
      if (slot > 56) begin
        while (slot < 64) begin
          blk[slot] = 8'h00;
          slot++;
        end
        fold_block();
        slot = 0;
      end
      while (slot < 56) begin
        blk[slot] = 8'h00;
        slot++;
      end
      for (i = 0; i < 8; i++)
        blk[56 + i] = bitlen[63 - 8 * i -: 8];
      fold_block();
      for (i = 0; i < 8; i++)
        digest_words_pending.push_back('{digest_word: chain[i], word_index: 3'(i),
                                         last_word: (3'(i) == sha256_pkg::LastWord)});
      chain = START_H;
      nbytes = '0;
    end
  endtask

  task automatic check_word(input sha256_pkg::digest_t got);
    sha256_pkg::digest_t want;
    if (digest_words_pending.size() == 0) begin
      if (bad < 10)
        $display("%0t ERROR unexpected digest transfer: word %h index %0d last %0b",
                 $time, got.digest_word, got.word_index, got.last_word);
      bad++;
      return;
    end
    want = digest_words_pending.pop_front();
    if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
        got.last_word !== want.last_word) begin
      if (bad < 10)
        $display("%0t ERROR digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b", $time,
                 want.digest_word, want.word_index, want.last_word,
                 got.digest_word, got.word_index, got.last_word);
      bad++;
    end
    checked++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chain = START_H;
      nbytes = '0;
      digest_words_pending.delete();
      bad = 0;
      checked = 0;
    end else begin
      if (item_valid && !item_stall)
        absorb_item(item);
      if (digest_valid && !digest_stall)
        check_word(digest);
    end
    mismatches    <= bad;
    words_due     <= digest_words_pending.size();
    words_checked <= checked;
  end

endmodule

### verif/tb_sha256_stream_hasher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_top
// Byte-serial SHA-256 hasher test: a short directed set (empty message,
// "abc", filler items, extreme bytes) and then random messages, mostly short
// and some on the padding boundaries, with random gaps on the byte side and
// random stalls on the digest side. The checker beside the block predicts
// and compares every digest word.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_top;

  // Longest legal quiet spell is a two-block finish behind a long sink stall;
  // this is many times that.
  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 330;
  // Cycles to linger after the last digest word, to catch stray transfers.
  localparam int DRAIN_CYCLES = 300;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                item_valid   = 1'b0;
  logic                item_stall;
  sha256_pkg::item_t   item         = '0;
  logic                digest_valid;
  logic                digest_stall = 1'b0;
  sha256_pkg::digest_t digest;

  int mismatches;
  int words_due;
  int words_checked;

  // Sender/sink pacing; "calm" spells run with no idling at all.
  bit src_calm  = 1'b0;
  bit sink_calm = 1'b0;
  int sink_hold = 0;
  int idle_cycles = 0;

  // Stimulus bookkeeping for the summary.
  int msgs_sent    = 0;
  int bytes_sent   = 0;
  int real_items   = 0;
  int filler_items = 0;

  sha256_stream_hasher_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest       (digest)
  );

  sha256_hash_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .digest_valid  (digest_valid),
    .digest_stall  (digest_stall),
    .digest        (digest),
    .mismatches    (mismatches),
    .words_due     (words_due),
    .words_checked (words_checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Digest-side backpressure. One nonblocking write to digest_stall per edge.
  always @(posedge clk) begin : sink_pacing
    int n;
    if (sink_hold > 0) begin
      digest_stall <= 1'b1;
      sink_hold    <= sink_hold - 1;
    end else begin
      if ($urandom_range(59) == 0)
        sink_calm <= !sink_calm;
      n = sink_calm ? 0 : pick_idle();
      digest_stall <= (n > 0);
      sink_hold    <= (n > 0) ? n - 1 : 0;
    end
  end

  // Watchdog: any run of cycles with no transfer on either side is bounded.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (digest_valid && !digest_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one item and hold it until the transfer happens. Valid is raised
  // right away when there is no gap, so back-to-back items keep it high.
  task automatic push_item(input logic [7:0] data, input logic present, input logic eom);
    int gap;
    if ($urandom_range(24) == 0)
      src_calm = !src_calm;
    gap = src_calm ? 0 : pick_idle();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= '{data_byte: data, byte_present: present, end_of_message: eom};
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (present)
      bytes_sent++;
    if (eom)
      msgs_sent++;
    if (present || eom)
      real_items++;
    else
      filler_items++;
  endtask

  // One message of random bytes. The end marker rides on the last byte or
  // comes as a byteless item; filler items are sprinkled in as noise.
  task automatic send_message(input int len);
    logic tail_byte;
    int k;
    tail_byte = (len > 0) && ($urandom_range(1) == 1);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(11) == 0)
        push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, tail_byte && (k == len - 1));
    end
    if (!tail_byte)
      push_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // empty message: end marker with no byte on a zero count
    push_item(8'h00, 1'b0, 1'b1);
    // "abc", marker on the last byte
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    // extreme bytes with a filler item between them, byteless end marker
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hff, 1'b0, 1'b0);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'h5a, 1'b0, 1'b1);
    // single 0xff byte that also closes the message
    push_item(8'hff, 1'b1, 1'b1);
    // filler first, then an empty message: filler must not count as a byte
    push_item(8'ha5, 1'b0, 1'b0);
    push_item(8'hff, 1'b0, 1'b1);
    // two empty messages back to back: state must be back at the start
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);

    // --- random messages ---
    // Mostly short ones; the rest sit on the one/two-block padding edges.
    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(12);
      end else begin
        case ($urandom_range(7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end
      send_message(len);
    end
    item_valid <= 1'b0;

    // Let the checker see the last transfer, then drain and linger.
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d messages, %0d message bytes, %0d filler items.",
             msgs_sent, bytes_sent, filler_items);
    $display("Digest words checked: %0d, bad transfers: %0d, still outstanding: %0d.",
             words_checked, mismatches, words_due);
    if (mismatches == 0 && words_due == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
